### sv/bic_pkg.sv
package bic_pkg;

    // Bank sizes
    localparam int BASIC_SOURCES    = 8;
    localparam int SOURCES_PER_BANK = 32;

    // Item actions
    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Register indexes (byte offset / 4)
    localparam logic [3:0] REG_PEND_TOP   = 4'd0;
    localparam logic [3:0] REG_PEND_1     = 4'd1;
    localparam logic [3:0] REG_PEND_2     = 4'd2;
    localparam logic [3:0] REG_FIQ_CTRL   = 4'd3;
    localparam logic [3:0] REG_EN_1       = 4'd4;
    localparam logic [3:0] REG_EN_2       = 4'd5;
    localparam logic [3:0] REG_EN_BASIC   = 4'd6;
    localparam logic [3:0] REG_DIS_1      = 4'd7;
    localparam logic [3:0] REG_DIS_2      = 4'd8;
    localparam logic [3:0] REG_DIS_BASIC  = 4'd9;

    // Shortcut lines: bank 1 entries first, then bank 2
    localparam int SC_COUNT  = 11;
    localparam int SC1_COUNT = 5;
    localparam int SC_FIRST  = 10;
    localparam logic [4:0] SC_LINE [SC_COUNT] = '{
        5'd7, 5'd9, 5'd10, 5'd18, 5'd19,
        5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd30
    };

    // Bank line masks covered by the shortcut bits
    localparam logic [31:0] SC1_LINE_MASK = 32'h000c_0680;
    localparam logic [31:0] SC2_LINE_MASK = 32'h43e0_0000;

    // FIQ control fields
    localparam int FIQ_EN_BIT = 7;
    localparam logic [6:0] FIQ_BANK2_START = 7'd32;
    localparam logic [6:0] FIQ_BASIC_START = 7'd64;
    localparam logic [6:0] FIQ_BASIC_END   = 7'd72;

    // Lowest set bit of a word, zero when none
    function automatic logic [4:0] low_bit(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // Top pending word
    function automatic logic [31:0] top_word(
        input logic [BASIC_SOURCES-1:0]    bp,
        input logic [SOURCES_PER_BANK-1:0] p1,
        input logic [SOURCES_PER_BANK-1:0] p2
    );
        logic [31:0] w;
        w = '0;
        w[BASIC_SOURCES-1:0] = bp;
        w[8] = |(p1 & ~SC1_LINE_MASK);
        w[9] = |(p2 & ~SC2_LINE_MASK);
        for (int i = 0; i < SC_COUNT; i++) begin
            if (i < SC1_COUNT) begin
                w[SC_FIRST + i] = p1[SC_LINE[i]];
            end else begin
                w[SC_FIRST + i] = p2[SC_LINE[i]];
            end
        end
        return w;
    endfunction

endpackage

### sv/banked_interrupt_controller.sv
// Three-bank level interrupt controller: 8 basic lines and two banks of 32 lines.
// Each item is a register read, a register write or a sample of the line levels,
// and gives exactly one result: read data (taken before the item's update) and
// the IRQ request, FIQ request and next source by handler priority (taken after
// it). One item is accepted every cycle unless o_stall is high; its result is registered in
// the output stage, or in the skid stage while an earlier result waits. The register update,
// pending masks and priority encoder are one combinational pass into the result register,
// and a one-entry skid stage lets the input keep flowing while a result waits at the output.
module banked_interrupt_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_basic_lines,
    input  logic [31:0] i_bank1_lines,
    input  logic [31:0] i_bank2_lines,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq_request,
    output logic        o_fiq_request,
    output logic [6:0]  o_next_source,
    output logic        o_next_valid
);

    localparam int NB = bic_pkg::BASIC_SOURCES;
    localparam int NS = bic_pkg::SOURCES_PER_BANK;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        fiq;
        logic [6:0]  next_source;
        logic        next_valid;
    } t_result;

    // Block state
    logic [NB-1:0] r_basic_enable, n_basic_enable;
    logic [NS-1:0] r_bank1_enable, n_bank1_enable;
    logic [NS-1:0] r_bank2_enable, n_bank2_enable;
    logic [7:0]    r_fiq_control,  n_fiq_control;
    logic [NB-1:0] r_basic_level,  n_basic_level;
    logic [NS-1:0] r_bank1_level,  n_bank1_level;
    logic [NS-1:0] r_bank2_level,  n_bank2_level;

    // Output and skid stages
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result res;

    logic in_take, out_take;
    bic_pkg::t_action act;

    logic [NB-1:0] bp_pre, bp;
    logic [NS-1:0] p1_pre, p2_pre, p1, p2;
    logic [6:0]    fiq_sel;

    assign o_stall  = r_skid_valid;
    assign in_take  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign act      = bic_pkg::t_action'(i_action);

    // Next state for the item at the input
    always_comb begin
        n_basic_enable = r_basic_enable;
        n_bank1_enable = r_bank1_enable;
        n_bank2_enable = r_bank2_enable;
        n_fiq_control  = r_fiq_control;
        n_basic_level  = r_basic_level;
        n_bank1_level  = r_bank1_level;
        n_bank2_level  = r_bank2_level;
        if (act == bic_pkg::ACT_WRITE) begin
            unique case (i_reg_index)
                bic_pkg::REG_FIQ_CTRL:  n_fiq_control  = i_write_data[7:0];
                bic_pkg::REG_EN_1:      n_bank1_enable = r_bank1_enable | i_write_data;
                bic_pkg::REG_EN_2:      n_bank2_enable = r_bank2_enable | i_write_data;
                bic_pkg::REG_EN_BASIC:
                    n_basic_enable = r_basic_enable | i_write_data[NB-1:0];
                bic_pkg::REG_DIS_1:     n_bank1_enable = r_bank1_enable & ~i_write_data;
                bic_pkg::REG_DIS_2:     n_bank2_enable = r_bank2_enable & ~i_write_data;
                bic_pkg::REG_DIS_BASIC:
                    n_basic_enable = r_basic_enable & ~i_write_data[NB-1:0];
                default: ;
            endcase
        end else if (act == bic_pkg::ACT_SAMPLE) begin
            n_basic_level = i_basic_lines;
            n_bank1_level = i_bank1_lines;
            n_bank2_level = i_bank2_lines;
        end
    end

    // Pending masks before and after the update
    assign bp_pre = r_basic_level & r_basic_enable;
    assign p1_pre = r_bank1_level & r_bank1_enable;
    assign p2_pre = r_bank2_level & r_bank2_enable;
    assign bp     = n_basic_level & n_basic_enable;
    assign p1     = n_bank1_level & n_bank1_enable;
    assign p2     = n_bank2_level & n_bank2_enable;
    assign fiq_sel = n_fiq_control[6:0];

    // Build the result word
    always_comb begin
        res = '0;
        if (act == bic_pkg::ACT_READ) begin
            unique case (i_reg_index)
                bic_pkg::REG_PEND_TOP: res.read_data = bic_pkg::top_word(bp_pre, p1_pre, p2_pre);
                bic_pkg::REG_PEND_1:   res.read_data = p1_pre;
                bic_pkg::REG_PEND_2:   res.read_data = p2_pre;
                bic_pkg::REG_FIQ_CTRL: res.read_data = {24'd0, r_fiq_control};
                bic_pkg::REG_EN_1, bic_pkg::REG_DIS_1:
                    res.read_data = r_bank1_enable;
                bic_pkg::REG_EN_2, bic_pkg::REG_DIS_2:
                    res.read_data = r_bank2_enable;
                bic_pkg::REG_EN_BASIC, bic_pkg::REG_DIS_BASIC:
                    res.read_data = {{(32-NB){1'b0}}, r_basic_enable};
                default: res.read_data = '0;
            endcase
        end

        res.irq = (|bp) || (|p1) || (|p2);

        // Pick the FIQ line from the selected bank
        if (n_fiq_control[bic_pkg::FIQ_EN_BIT]) begin
            if (fiq_sel < bic_pkg::FIQ_BANK2_START) begin
                res.fiq = n_bank1_level[fiq_sel[4:0]];
            end else if (fiq_sel < bic_pkg::FIQ_BASIC_START) begin
                res.fiq = n_bank2_level[fiq_sel[4:0]];
            end else if (fiq_sel < bic_pkg::FIQ_BASIC_END) begin
                res.fiq = n_basic_level[fiq_sel[2:0]];
            end
        end

        // Handler priority: basic, bank 1 shortcuts, bank 2 shortcuts, bank 1, bank 2
        res.next_valid = 1'b1;
        if (|bp) begin
            res.next_source = {2'd0, bic_pkg::low_bit({{(32-NB){1'b0}}, bp})};
        end else if (|(p1 & bic_pkg::SC1_LINE_MASK)) begin
            res.next_source = {2'd1, bic_pkg::low_bit(p1 & bic_pkg::SC1_LINE_MASK)};
        end else if (|(p2 & bic_pkg::SC2_LINE_MASK)) begin
            res.next_source = {2'd2, bic_pkg::low_bit(p2 & bic_pkg::SC2_LINE_MASK)};
        end else if (|p1) begin
            res.next_source = {2'd1, bic_pkg::low_bit(p1)};
        end else if (|p2) begin
            res.next_source = {2'd2, bic_pkg::low_bit(p2)};
        end else begin
            res.next_source = '0;
            res.next_valid  = 1'b0;
        end
    end

    // Hold state and advance the output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basic_enable <= '0;
            r_bank1_enable <= '0;
            r_bank2_enable <= '0;
            r_fiq_control  <= '0;
            r_basic_level  <= '0;
            r_bank1_level  <= '0;
            r_bank2_level  <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (in_take) begin
                r_basic_enable <= n_basic_enable;
                r_bank1_enable <= n_bank1_enable;
                r_bank2_enable <= n_bank2_enable;
                r_fiq_control  <= n_fiq_control;
                r_basic_level  <= n_basic_level;
                r_bank1_level  <= n_bank1_level;
                r_bank2_level  <= n_bank2_level;
            end
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= res;
                    r_out_valid <= in_take;
                end
            end else if (in_take) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out.read_data;
    assign o_irq_request = r_out.irq;
    assign o_fiq_request = r_out.fiq;
    assign o_next_source = r_out.next_source;
    assign o_next_valid  = r_out.next_valid;

`ifndef NO_ASSERTIONS
    // Skid entry only exists behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output stage empty");

    // A named next source is always a pending one
    a_next_needs_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_next_valid |-> o_irq_request)
        else $error("next source valid without a pending interrupt");

    a_irq_needs_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_irq_request |-> o_next_valid)
        else $error("pending interrupt without a next source");

    // Skid item moves forward when the output is taken
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid && !r_skid_valid)
        else $error("skid item not moved to output");

    // Output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

### bench/tb_banked_interrupt_controller.sv
module tb_banked_interrupt_controller;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          RANDOM_ITEMS    = 1000;
    localparam logic [3:0]  REG_UNUSED_LOW  = 4'd10;
    localparam logic [3:0]  REG_UNUSED_HIGH = 4'd15;
    localparam logic [7:0]  FIQ_ENABLE      = 8'h80;

    // Bank lines that have their own bit in the top word, bank 1 entries first
    localparam int          SHORTCUTS       = 11;
    localparam int          BANK1_SHORTCUTS = 5;
    localparam int          SHORTCUT_BASE   = 10;
    localparam int          SHORTCUT_LINE [SHORTCUTS] = '{
        7, 9, 10, 18, 19, 21, 22, 23, 24, 25, 30
    };

    typedef struct {
        bic_pkg::t_action act;
        logic [3:0]  idx;
        logic [31:0] wdata;
        logic [7:0]  basic;
        logic [31:0] bank1;
        logic [31:0] bank2;
    } t_irq_item;

    typedef struct {
        logic [31:0] read_data;
        logic        irq;
        logic        fiq;
        logic [6:0]  source;
        logic        source_valid;
    } t_irq_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [3:0]  i_reg_index;
    logic [31:0] i_write_data;
    logic [7:0]  i_basic_lines;
    logic [31:0] i_bank1_lines;
    logic [31:0] i_bank2_lines;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_read_data;
    logic        o_irq_request;
    logic        o_fiq_request;
    logic [6:0]  o_next_source;
    logic        o_next_valid;

    // Shadow copy of the controller registers
    logic [7:0]  basic_en;
    logic [31:0] bank1_en;
    logic [31:0] bank2_en;
    logic [7:0]  fiq_ctrl;
    logic [7:0]  basic_lvl;
    logic [31:0] bank1_lvl;
    logic [31:0] bank2_lvl;

    t_irq_response responses_due[$];
    int            mismatches;
    int            responses_seen;
    int            cycle_count;
    bit            steady;

    banked_interrupt_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_reg_index   (i_reg_index),
        .i_write_data  (i_write_data),
        .i_basic_lines (i_basic_lines),
        .i_bank1_lines (i_bank1_lines),
        .i_bank2_lines (i_bank2_lines),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_irq_request (o_irq_request),
        .o_fiq_request (o_fiq_request),
        .o_next_source (o_next_source),
        .o_next_valid  (o_next_valid)
    );

    // Generate the clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int lowest_set(input logic [31:0] v);
        int r;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = i;
            end
        end
        return r;
    endfunction

    // Build the top pending word from the three pending masks
    function automatic logic [31:0] pending_summary(
        input logic [7:0]  bp,
        input logic [31:0] p1,
        input logic [31:0] p2
    );
        logic [31:0] w;
        logic [31:0] cover1;
        logic [31:0] cover2;
        w = {24'd0, bp};
        cover1 = '0;
        cover2 = '0;
        for (int i = 0; i < SHORTCUTS; i++) begin
            if (i < BANK1_SHORTCUTS) begin
                cover1[SHORTCUT_LINE[i]] = 1'b1;
                w[SHORTCUT_BASE + i] = p1[SHORTCUT_LINE[i]];
            end else begin
                cover2[SHORTCUT_LINE[i]] = 1'b1;
                w[SHORTCUT_BASE + i] = p2[SHORTCUT_LINE[i]];
            end
        end
        w[8] = |(p1 & ~cover1);
        w[9] = |(p2 & ~cover2);
        return w;
    endfunction

    // Apply one item to the shadow registers and return its response
    function automatic t_irq_response predict_response(input t_irq_item it);
        t_irq_response r;
        logic [7:0]    bp;
        logic [31:0]   p1;
        logic [31:0]   p2;
        logic [31:0]   w;
        logic [6:0]    sel;
        int            tier;
        r = '{default: '0};
        bp = basic_lvl & basic_en;
        p1 = bank1_lvl & bank1_en;
        p2 = bank2_lvl & bank2_en;

        // Read data comes from the state before the update
        if (it.act == bic_pkg::ACT_READ) begin
            case (it.idx)
                bic_pkg::REG_PEND_TOP: r.read_data = pending_summary(bp, p1, p2);
                bic_pkg::REG_PEND_1:   r.read_data = p1;
                bic_pkg::REG_PEND_2:   r.read_data = p2;
                bic_pkg::REG_FIQ_CTRL: r.read_data = {24'd0, fiq_ctrl};
                bic_pkg::REG_EN_1, bic_pkg::REG_DIS_1:
                    r.read_data = bank1_en;
                bic_pkg::REG_EN_2, bic_pkg::REG_DIS_2:
                    r.read_data = bank2_en;
                bic_pkg::REG_EN_BASIC, bic_pkg::REG_DIS_BASIC:
                    r.read_data = {24'd0, basic_en};
                default:               r.read_data = '0;
            endcase
        end else if (it.act == bic_pkg::ACT_WRITE) begin
            case (it.idx)
                bic_pkg::REG_FIQ_CTRL:  fiq_ctrl = it.wdata[7:0];
                bic_pkg::REG_EN_1:      bank1_en = bank1_en | it.wdata;
                bic_pkg::REG_EN_2:      bank2_en = bank2_en | it.wdata;
                bic_pkg::REG_EN_BASIC:  basic_en = basic_en | it.wdata[7:0];
                bic_pkg::REG_DIS_1:     bank1_en = bank1_en & ~it.wdata;
                bic_pkg::REG_DIS_2:     bank2_en = bank2_en & ~it.wdata;
                bic_pkg::REG_DIS_BASIC: basic_en = basic_en & ~it.wdata[7:0];
                default:                ;
            endcase
        end else if (it.act == bic_pkg::ACT_SAMPLE) begin
            basic_lvl = it.basic;
            bank1_lvl = it.bank1;
            bank2_lvl = it.bank2;
        end

        // Requests and next source come from the state after the update
        bp = basic_lvl & basic_en;
        p1 = bank1_lvl & bank1_en;
        p2 = bank2_lvl & bank2_en;
        w = pending_summary(bp, p1, p2);
        r.irq = |{bp, p1, p2};

        sel = fiq_ctrl[6:0];
        if ((fiq_ctrl & FIQ_ENABLE) != 0) begin
            if (sel < 7'd32) begin
                r.fiq = bank1_lvl[sel[4:0]];
            end else if (sel < 7'd64) begin
                r.fiq = bank2_lvl[sel[4:0]];
            end else if (sel < 7'd72) begin
                r.fiq = basic_lvl[sel[2:0]];
            end
        end

        // Walk the handler priority: basic, shortcuts, then bank flags
        if (w[7:0] != 0) begin
            r.source = 7'(lowest_set({24'd0, w[7:0]}));
            r.source_valid = 1'b1;
        end else if (w[SHORTCUT_BASE +: SHORTCUTS] != 0) begin
            tier = lowest_set({21'd0, w[SHORTCUT_BASE +: SHORTCUTS]});
            r.source = 7'(SHORTCUT_LINE[tier]
                          + (tier < BANK1_SHORTCUTS ? 32 : 64));
            r.source_valid = 1'b1;
        end else if (w[8]) begin
            r.source = 7'(32 + lowest_set(p1));
            r.source_valid = 1'b1;
        end else if (w[9]) begin
            r.source = 7'(64 + lowest_set(p2));
            r.source_valid = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at response %0d: %s expected %h got %h",
                 responses_seen, what, want, got);
        mismatches++;
    endtask

    task automatic check_response();
        t_irq_response want;
        if (responses_due.size() == 0) begin
            report_mismatch("response with none pending", '0, o_read_data);
        end else begin
            want = responses_due.pop_front();
            if (o_read_data !== want.read_data)
                report_mismatch("read_data", want.read_data, o_read_data);
            if (o_irq_request !== want.irq)
                report_mismatch("irq_request", 32'(want.irq), 32'(o_irq_request));
            if (o_fiq_request !== want.fiq)
                report_mismatch("fiq_request", 32'(want.fiq), 32'(o_fiq_request));
            if (o_next_source !== want.source)
                report_mismatch("next_source", 32'(want.source), 32'(o_next_source));
            if (o_next_valid !== want.source_valid)
                report_mismatch("next_valid", 32'(want.source_valid),
                                32'(o_next_valid));
        end
        responses_seen++;
    endtask

    // Take responses and stall the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_response();
            end
            i_stall <= !steady && ($urandom_range(99) < 26);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Hand one item to the controller and record its response once accepted
    task automatic send_item(input t_irq_item it);
        if (!steady && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= it.act;
        i_reg_index   <= it.idx;
        i_write_data  <= it.wdata;
        i_basic_lines <= it.basic;
        i_bank1_lines <= it.bank1;
        i_bank2_lines <= it.bank2;
        do @(posedge i_clk); while (o_stall);
        responses_due.push_back(predict_response(it));
    endtask

    // Hold the input until every response is back
    task automatic wait_responses_drained();
        i_valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_irq_item make_item(
        input bic_pkg::t_action act, input logic [3:0] idx, input logic [31:0] wdata,
        input logic [7:0] basic, input logic [31:0] bank1, input logic [31:0] bank2
    );
        t_irq_item it;
        it.act   = act;
        it.idx   = idx;
        it.wdata = wdata;
        it.basic = basic;
        it.bank1 = bank1;
        it.bank2 = bank2;
        return it;
    endfunction

    // Mostly sparse words so the lower priority tiers get reached
    function automatic logic [31:0] line_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 15) return '1;
        if (pick < 40) return 32'd1 << $urandom_range(31);
        if (pick < 70) return $urandom & $urandom & $urandom;
        return $urandom;
    endfunction

    function automatic t_irq_item random_item();
        t_irq_item it;
        int        pick;
        pick = $urandom_range(99);
        it = make_item(bic_pkg::ACT_READ, 4'($urandom_range(15)), $urandom,
                       8'(line_word()), line_word(), line_word());
        if (pick < 35) begin
            it.act = bic_pkg::ACT_SAMPLE;
        end else if (pick < 70) begin
            it.act = bic_pkg::ACT_WRITE;
            it.idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(3, 9));
            if (it.idx == bic_pkg::REG_FIQ_CTRL) begin
                // Upper junk bits, then a source that sometimes names no line
                it.wdata = {$urandom_range(1) ? 24'hffffff : 24'd0, 1'b0,
                            7'($urandom_range(79))};
                it.wdata[7] = $urandom_range(3) != 0;
            end else if (it.idx >= bic_pkg::REG_DIS_1 &&
                         it.idx <= bic_pkg::REG_DIS_BASIC) begin
                it.wdata = line_word();
            end
        end else if (pick < 95) begin
            it.act = bic_pkg::ACT_READ;
        end else begin
            it.act = bic_pkg::ACT_NONE;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_state();
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_PEND_TOP, '1, '1, '1, '1));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_FIQ_CTRL, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_DIS_BASIC, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_READ, REG_UNUSED_HIGH, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_NONE, bic_pkg::REG_EN_1, '1, '1, '1, '1));
    endtask

    task automatic test_enable_masks();
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_EN_1, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_EN_2, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_EN_BASIC, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_EN_BASIC, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_PEND_1, '1, '0, '0, '0));
    endtask

    task automatic test_priority_order();
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, '1, '1, '1));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_PEND_TOP, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, 8'h80,
                            32'h8000_0000, 32'h4000_0000));
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, '0,
                            32'h8008_0000, 32'h4000_0001));
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, '0, '0,
                            32'h0000_0001));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_PEND_2, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_PEND_1, '0, '0, '0, '0));
    endtask

    task automatic test_fiq_select();
        send_item(make_item(bic_pkg::ACT_SAMPLE, bic_pkg::REG_PEND_TOP, '0, 8'h80,
                            32'h8000_0000, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_FIQ_CTRL, 32'h0000_00c7,
                            '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_FIQ_CTRL, 32'hffff_ffc8,
                            '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_FIQ_CTRL, 32'h0000_001f,
                            '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_FIQ_CTRL, 32'hffff_ff9f,
                            '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_READ, bic_pkg::REG_FIQ_CTRL, '0, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, REG_UNUSED_LOW, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_DIS_1, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_DIS_2, '1, '0, '0, '0));
        send_item(make_item(bic_pkg::ACT_WRITE, bic_pkg::REG_DIS_BASIC, '1, '0, '0, '0));
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Drain once midway, then run a stretch with no idling at all
            if (n == RANDOM_ITEMS / 2) begin
                wait_responses_drained();
                @(posedge i_clk);
            end
            steady = (n >= 600 && n < 750);
            send_item(random_item());
        end
        steady = 1'b0;
    endtask

    initial begin
        mismatches     = 0;
        responses_seen = 0;
        steady         = 1'b0;
        cycle_count    = 0;
        basic_en  = '0;
        bank1_en  = '0;
        bank2_en  = '0;
        fiq_ctrl  = '0;
        basic_lvl = '0;
        bank1_lvl = '0;
        bank2_lvl = '0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= bic_pkg::ACT_READ;
        i_reg_index   <= bic_pkg::REG_PEND_TOP;
        i_write_data  <= '0;
        i_basic_lines <= '0;
        i_bank1_lines <= '0;
        i_bank2_lines <= '0;
        i_stall       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_enable_masks();
        test_priority_order();
        test_fiq_select();
        test_random_traffic();

        wait_responses_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
